>>> sv/mfp_pkg.sv
// ----------------------------------------------------------------------------
// Motor frame parser package
// Payload types, result kinds, error codes and register indexes.
// ----------------------------------------------------------------------------
package mfp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CONTROLLED   = 2'd0;
  localparam logic [1:0] KIND_UNCONTROLLED = 2'd1;
  localparam logic [1:0] KIND_BRUSHLESS    = 2'd2;
  localparam logic [1:0] KIND_STATUS       = 2'd3;

  // Status error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_SHORT = 2'd1;
  localparam logic [1:0] ERR_LENGTH    = 2'd2;
  localparam logic [1:0] ERR_BAD_ID    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_CONTROLLED_LIMIT   = 2'd0;
  localparam logic [1:0] REG_UNCONTROLLED_LIMIT = 2'd1;
  localparam logic [1:0] REG_BRUSHLESS_LIMIT    = 2'd2;

  localparam logic [7:0] ID_LIMIT_RESET = 8'd16;

  // Flag byte bit positions
  localparam int FLAG_FINISHED_BIT = 1;
  localparam int FLAG_NEWCMD_BIT   = 0;

  // Output queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [1:0] record_kind;
    logic [7:0] motor_id;
    logic [7:0] target_angle;
    logic [7:0] target_turns;
    logic       finished_flag;
    logic       new_command_flag;
    logic [7:0] switch_value;
    logic       rotation_flag;
    logic       frame_ok;
    logic [1:0] error_code;
    logic       run_last;
  } out_t;

endpackage

>>> sv/motor_frame_parser_top.sv
// ----------------------------------------------------------------------------
// Motor frame parser
// Each accepted byte can push results into the four-entry output queue, whose
// entries are registered. Accepts one byte per cycle while in_stall is low (the
// queue holds at most two entries); a final byte that also completes a valid
// record gives two results, the record first and the status behind it. Sync
// reset clears the parse state and the queue and sets every id limit to 16.
// ----------------------------------------------------------------------------
module motor_frame_parser_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mfp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mfp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);
  import mfp_pkg::*;

  typedef enum logic [1:0] {
    SEC_HEADER    = 2'd0,
    SEC_CTRL      = 2'd1,
    SEC_UNCTRL    = 2'd2,
    SEC_BRUSHLESS = 2'd3
  } section_t;

  typedef struct packed {
    section_t   sec;
    logic [7:0] left;
  } entry_t;

  // Pick the first section at or after 'from' that has records.
  function automatic entry_t enter_section(input logic [1:0] from, input logic [7:0] cc,
                                           input logic [7:0] uc, input logic [7:0] bc);
    entry_t e;
    e.sec  = SEC_BRUSHLESS;
    e.left = '0;
    if (from <= SEC_CTRL && cc != 8'd0) begin
      e.sec  = SEC_CTRL;
      e.left = cc;
    end else if (from <= SEC_UNCTRL && uc != 8'd0) begin
      e.sec  = SEC_UNCTRL;
      e.left = uc;
    end else if (bc != 8'd0) begin
      e.sec  = SEC_BRUSHLESS;
      e.left = bc;
    end
    return e;
  endfunction

  // Configuration
  logic [7:0] controlled_id_limit, uncontrolled_id_limit, brushless_id_limit;

  // Parse state
  logic [7:0] byte_position, controlled_count, uncontrolled_count, brushless_count;
  section_t   section;
  logic [7:0] records_left;
  logic [1:0] field_index;
  logic [7:0] staged_id, staged_angle, staged_turns;
  logic       bad_id_seen, overlength_seen;

  logic [7:0] byte_position_next, controlled_count_next, uncontrolled_count_next;
  logic [7:0] brushless_count_next, records_left_next;
  section_t   section_next;
  logic [1:0] field_index_next;
  logic [7:0] staged_id_next, staged_angle_next, staged_turns_next;
  logic       bad_id_seen_next, overlength_seen_next;

  // Output queue
  out_t              queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   fill;

  logic       accept, pop;
  logic [7:0] b;
  logic       rec_valid;
  out_t       rec, status;
  logic [7:0] limit;
  logic [1:0] code;
  logic [10:0] expect_len;
  entry_t     ent;
  logic [7:0] left_dec;
  logic [1:0] push_n;

  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = fill > (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);
  assign out_valid = fill != '0;
  assign out_data  = queue[rd_ptr];
  assign b         = in_data.frame_byte;

  always_comb begin
    byte_position_next      = byte_position;
    controlled_count_next   = controlled_count;
    uncontrolled_count_next = uncontrolled_count;
    brushless_count_next    = brushless_count;
    section_next            = section;
    records_left_next       = records_left;
    field_index_next        = field_index;
    staged_id_next          = staged_id;
    staged_angle_next       = staged_angle;
    staged_turns_next       = staged_turns;
    bad_id_seen_next        = bad_id_seen;
    overlength_seen_next    = overlength_seen;
    rec       = '0;
    rec_valid = 1'b0;
    limit     = brushless_id_limit;
    ent       = '0;
    left_dec  = records_left - 8'd1;

    if (byte_position == 8'd255) begin
      overlength_seen_next = 1'b1;
    end else begin
      byte_position_next = byte_position + 8'd1;
    end

    if (section == SEC_HEADER) begin
      if (byte_position_next == 8'd1) begin
        controlled_count_next = b;
      end else if (byte_position_next == 8'd2) begin
        uncontrolled_count_next = b;
      end else begin
        brushless_count_next = b;
        ent = enter_section(SEC_CTRL, controlled_count, uncontrolled_count, b);
        section_next      = ent.sec;
        records_left_next = ent.left;
        field_index_next  = 2'd0;
      end
    end else if (records_left != 8'd0) begin
      if (field_index == 2'd0) begin
        staged_id_next = b;
        case (section)
          SEC_CTRL:   limit = controlled_id_limit;
          SEC_UNCTRL: limit = uncontrolled_id_limit;
          default:    limit = brushless_id_limit;
        endcase
        if (b == 8'd0 || b >= limit) bad_id_seen_next = 1'b1;
        field_index_next = 2'd1;
      end else if (section == SEC_CTRL && field_index == 2'd1) begin
        staged_angle_next = b;
        field_index_next  = 2'd2;
      end else if (section == SEC_CTRL && field_index == 2'd2) begin
        staged_turns_next = b;
        field_index_next  = 2'd3;
      end else begin
        // Record complete: emit unless an id was bad, then advance
        rec_valid    = !bad_id_seen;
        rec.motor_id = staged_id;
        case (section)
          SEC_CTRL: begin
            rec.record_kind      = KIND_CONTROLLED;
            rec.target_angle     = staged_angle;
            rec.target_turns     = staged_turns;
            rec.finished_flag    = b[FLAG_FINISHED_BIT];
            rec.new_command_flag = b[FLAG_NEWCMD_BIT];
          end
          SEC_UNCTRL: begin
            rec.record_kind   = KIND_UNCONTROLLED;
            rec.switch_value  = {7'd0, b[FLAG_FINISHED_BIT]};
            rec.rotation_flag = b[FLAG_NEWCMD_BIT];
          end
          default: begin
            rec.record_kind  = KIND_BRUSHLESS;
            rec.switch_value = b;
          end
        endcase
        rec.run_last      = !in_data.frame_end;
        field_index_next  = 2'd0;
        records_left_next = left_dec;
        if (left_dec == 8'd0 && section != SEC_BRUSHLESS) begin
          ent = enter_section((section == SEC_CTRL) ? SEC_UNCTRL : SEC_BRUSHLESS,
                              controlled_count, uncontrolled_count, brushless_count);
          section_next      = ent.sec;
          records_left_next = ent.left;
        end
      end
    end

    expect_len = 11'd3 + {1'b0, controlled_count_next, 2'b00}
               + {2'b00, uncontrolled_count_next, 1'b0}
               + {2'b00, brushless_count_next, 1'b0};
    if (!overlength_seen_next && byte_position_next < 8'd3) begin
      code = ERR_TOO_SHORT;
    end else if (overlength_seen_next || {3'b000, byte_position_next} != expect_len) begin
      code = ERR_LENGTH;
    end else if (bad_id_seen_next) begin
      code = ERR_BAD_ID;
    end else begin
      code = ERR_NONE;
    end
    status             = '0;
    status.record_kind = KIND_STATUS;
    status.frame_ok    = (code == ERR_NONE);
    status.error_code  = code;
    status.run_last    = 1'b1;

    push_n = '0;
    if (accept) begin
      push_n = {1'b0, rec_valid} + {1'b0, in_data.frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      controlled_id_limit   <= ID_LIMIT_RESET;
      uncontrolled_id_limit <= ID_LIMIT_RESET;
      brushless_id_limit    <= ID_LIMIT_RESET;
      byte_position      <= '0;
      controlled_count   <= '0;
      uncontrolled_count <= '0;
      brushless_count    <= '0;
      section            <= SEC_HEADER;
      records_left       <= '0;
      field_index        <= '0;
      staged_id          <= '0;
      staged_angle       <= '0;
      staged_turns       <= '0;
      bad_id_seen        <= 1'b0;
      overlength_seen    <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CONTROLLED_LIMIT:   controlled_id_limit   <= cfg_data;
          REG_UNCONTROLLED_LIMIT: uncontrolled_id_limit <= cfg_data;
          REG_BRUSHLESS_LIMIT:    brushless_id_limit    <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        if (in_data.frame_end) begin
          // Drop all parse state at frame end
          byte_position      <= '0;
          controlled_count   <= '0;
          uncontrolled_count <= '0;
          brushless_count    <= '0;
          section            <= SEC_HEADER;
          records_left       <= '0;
          field_index        <= '0;
          staged_id          <= '0;
          staged_angle       <= '0;
          staged_turns       <= '0;
          bad_id_seen        <= 1'b0;
          overlength_seen    <= 1'b0;
        end else begin
          byte_position      <= byte_position_next;
          controlled_count   <= controlled_count_next;
          uncontrolled_count <= uncontrolled_count_next;
          brushless_count    <= brushless_count_next;
          section            <= section_next;
          records_left       <= records_left_next;
          field_index        <= field_index_next;
          staged_id          <= staged_id_next;
          staged_angle       <= staged_angle_next;
          staged_turns       <= staged_turns_next;
          bad_id_seen        <= bad_id_seen_next;
          overlength_seen    <= overlength_seen_next;
        end
      end

      wr_ptr <= wr_ptr + QUEUE_AW'(push_n);
      if (pop) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      fill <= fill + (QUEUE_AW + 1)'(push_n) - (QUEUE_AW + 1)'(pop);
    end
  end

  // Queue storage: record first, status behind it
  always_ff @(posedge clk) begin
    if (accept) begin
      if (rec_valid) begin
        queue[wr_ptr] <= rec;
        if (in_data.frame_end) queue[wr_ptr + QUEUE_AW'(1)] <= status;
      end else if (in_data.frame_end) begin
        queue[wr_ptr] <= status;
      end
    end
  end

endmodule
